// ===== sv/ccbf_pkg.sv =====
// Shared types and constants for the CAN capture block framer.
`timescale 1ns / 1ps
`default_nettype none

package ccbf_pkg;

   localparam logic [31:0] BLOCK_TYPE_EPB  = 32'h0000_0006;
   localparam logic [31:0] CLASSIC_CAPLEN  = 32'd16;
   localparam logic [31:0] FD_CAPLEN       = 32'd72;
   localparam logic [31:0] CLASSIC_TOTLEN  = 32'd48;
   localparam logic [31:0] FD_TOTLEN       = 32'd104;
   localparam logic [6:0]  CLASSIC_MAXLEN  = 7'd8;
   localparam logic [6:0]  FD_MAXLEN       = 7'd64;
   localparam logic [4:0]  CLASSIC_DWORDS  = 5'd2;
   localparam logic [4:0]  FD_DWORDS       = 5'd16;
   localparam logic [3:0]  HDR_LAST_IDX    = 4'd8;
   localparam logic        MODE_DESC       = 1'b0;
   localparam logic        MODE_BEAT       = 1'b1;

   typedef enum logic [2:0] {
      WSEL_ZERO,
      WSEL_HDR,
      WSEL_CLOSE,
      WSEL_DLO,
      WSEL_DHI
   } wsel_type;

   typedef struct packed {
      logic       load_desc;
      logic       load_beat;
      logic       emit;
      wsel_type   wsel;
      logic [3:0] hdr_idx;
      logic       flush_step;
      logic       close;
      logic       hdr_done;
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_open;
      logic dwl_zero;
      logic beats_zero;
      logic pend_beats_zero;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== sv/ccbf_ctrl.sv =====
// Sequencing state machine for the CAN capture block framer.
`timescale 1ns / 1ps
`default_nettype none

module ccbf_ctrl
   import ccbf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_mode,
   output logic             req_ready,
   input  wire dp_sts_type  sts,
   output ctl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_CLOSE,
      ST_HEADER,
      ST_DATA_LO,
      ST_DATA_HI
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] hdr_cnt_ff, hdr_cnt_in;
   logic       hdr_pend_ff, hdr_pend_in;

   always_comb begin
      state_in    = state_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      hdr_pend_in = hdr_pend_ff;
      cmd         = '0;
      cmd.wsel    = WSEL_ZERO;
      cmd.hdr_idx = hdr_cnt_ff;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_DESC) begin
                  cmd.load_desc = 1'b1;
                  hdr_pend_in   = 1'b1;
                  state_in      = sts.frame_open ? ST_FLUSH : ST_HEADER;
               end else if (sts.frame_open) begin
                  cmd.load_beat = 1'b1;
                  state_in      = ST_DATA_LO;
               end
            end
         end
         ST_FLUSH: begin
            if (sts.dwl_zero) begin
               state_in = ST_CLOSE;
            end else if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.wsel       = WSEL_ZERO;
               cmd.flush_step = 1'b1;
            end
         end
         ST_CLOSE: begin
            if (sts.out_free) begin
               cmd.emit  = 1'b1;
               cmd.wsel  = WSEL_CLOSE;
               cmd.close = 1'b1;
               state_in  = hdr_pend_ff ? ST_HEADER : ST_IDLE;
            end
         end
         ST_HEADER: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.wsel = WSEL_HDR;
               if (hdr_cnt_ff == HDR_LAST_IDX) begin
                  cmd.hdr_done = 1'b1;
                  hdr_cnt_in   = '0;
                  hdr_pend_in  = 1'b0;
                  state_in     = sts.pend_beats_zero ? ST_FLUSH : ST_IDLE;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 4'd1;
               end
            end
         end
         ST_DATA_LO: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.wsel = WSEL_DLO;
               state_in = ST_DATA_HI;
            end
         end
         ST_DATA_HI: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.wsel = WSEL_DHI;
               state_in = sts.beats_zero ? ST_FLUSH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         hdr_cnt_ff  <= '0;
         hdr_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         hdr_pend_ff <= hdr_pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ccbf_dp.sv =====
// Datapath of the CAN capture block framer: frame state, word select, output register.
`timescale 1ns / 1ps
`default_nettype none

module ccbf_dp
   import ccbf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic [31:0]  can_id,
   input  wire logic         is_fd,
   input  wire logic         is_error,
   input  wire logic         bit_rate_switch,
   input  wire logic [6:0]   length,
   input  wire logic [63:0]  timestamp_us,
   input  wire logic [63:0]  payload,
   input  wire ctl_cmd_type  cmd,
   output dp_sts_type        sts,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [31:0]       rsp_word,
   output logic              rsp_last
);

   logic [31:0] iface_ff;
   logic        open_ff, open_in;
   logic        fd_ff, fd_in;
   logic [6:0]  bytes_ff, bytes_in;
   logic [3:0]  beats_ff, beats_in;
   logic [4:0]  dwl_ff, dwl_in;

   logic [31:0] p_id_ff;
   logic        p_fd_ff;
   logic        p_brs_ff;
   logic [6:0]  p_len_ff;
   logic [63:0] p_ts_ff;
   logic [63:0] beat_ff;

   logic        valid_ff;
   logic [31:0] word_ff;
   logic        last_ff;

   logic        d_fd;
   logic [6:0]  d_len;
   logic [63:0] masked;
   logic [6:0]  take;
   logic [3:0]  p_beats;
   logic [31:0] hdr_word;
   logic [31:0] sel_word;

   // descriptor decode
   always_comb begin
      d_fd = is_fd & ~is_error;
      if (is_error) begin
         d_len = CLASSIC_MAXLEN;
      end else if (d_fd) begin
         d_len = (length > FD_MAXLEN) ? FD_MAXLEN : length;
      end else begin
         d_len = (length > CLASSIC_MAXLEN) ? CLASSIC_MAXLEN : length;
      end
   end

   // bytes past the valid count go out as zero
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[i*8 +: 8] = (bytes_ff > 7'(i)) ? payload[i*8 +: 8] : 8'h00;
      end
      take = (bytes_ff > CLASSIC_MAXLEN) ? CLASSIC_MAXLEN : bytes_ff;
   end

   assign p_beats = 4'((8'(p_len_ff) + 8'd7) >> 3);

   always_comb begin
      case (cmd.hdr_idx)
         4'd0:    hdr_word = BLOCK_TYPE_EPB;
         4'd1:    hdr_word = p_fd_ff ? FD_TOTLEN : CLASSIC_TOTLEN;
         4'd2:    hdr_word = iface_ff;
         4'd3:    hdr_word = p_ts_ff[63:32];
         4'd4:    hdr_word = p_ts_ff[31:0];
         4'd5:    hdr_word = p_fd_ff ? FD_CAPLEN : CLASSIC_CAPLEN;
         4'd6:    hdr_word = p_fd_ff ? FD_CAPLEN : CLASSIC_CAPLEN;
         4'd7:    hdr_word = {p_id_ff[7:0], p_id_ff[15:8], p_id_ff[23:16], p_id_ff[31:24]};
         4'd8:    hdr_word = {16'h0000, 7'd0, p_fd_ff & p_brs_ff, 1'b0, p_len_ff};
         default: hdr_word = '0;
      endcase
   end

   always_comb begin
      case (cmd.wsel)
         WSEL_ZERO:  sel_word = '0;
         WSEL_HDR:   sel_word = hdr_word;
         WSEL_CLOSE: sel_word = fd_ff ? FD_TOTLEN : CLASSIC_TOTLEN;
         WSEL_DLO:   sel_word = beat_ff[31:0];
         WSEL_DHI:   sel_word = beat_ff[63:32];
         default:    sel_word = '0;
      endcase
   end

   // frame state
   always_comb begin
      open_in  = open_ff;
      fd_in    = fd_ff;
      bytes_in = bytes_ff;
      beats_in = beats_ff;
      dwl_in   = dwl_ff;
      if (cmd.load_beat) begin
         bytes_in = bytes_ff - take;
         dwl_in   = (dwl_ff >= 5'd2) ? dwl_ff - 5'd2 : 5'd0;
         beats_in = (beats_ff != 4'd0) ? beats_ff - 4'd1 : 4'd0;
      end
      if (cmd.flush_step) begin
         dwl_in = dwl_ff - 5'd1;
      end
      if (cmd.close) begin
         open_in  = 1'b0;
         bytes_in = '0;
         beats_in = '0;
      end
      if (cmd.hdr_done) begin
         open_in  = 1'b1;
         fd_in    = p_fd_ff;
         bytes_in = p_len_ff;
         beats_in = p_beats;
         dwl_in   = p_fd_ff ? FD_DWORDS : CLASSIC_DWORDS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iface_ff <= '0;
         open_ff  <= 1'b0;
         fd_ff    <= 1'b0;
         bytes_ff <= '0;
         beats_ff <= '0;
         dwl_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            iface_ff <= csr_wdata;
         end
         open_ff  <= open_in;
         fd_ff    <= fd_in;
         bytes_ff <= bytes_in;
         beats_ff <= beats_in;
         dwl_ff   <= dwl_in;
         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_desc) begin
         p_id_ff  <= can_id;
         p_fd_ff  <= d_fd;
         p_brs_ff <= bit_rate_switch;
         p_len_ff <= d_len;
         p_ts_ff  <= timestamp_us;
      end
      if (cmd.load_beat) begin
         beat_ff <= masked;
      end
      if (cmd.emit) begin
         word_ff <= sel_word;
         last_ff <= (cmd.wsel == WSEL_CLOSE);
      end
   end

   assign sts.frame_open      = open_ff;
   assign sts.dwl_zero        = (dwl_ff == 5'd0);
   assign sts.beats_zero      = (beats_ff == 4'd0);
   assign sts.pend_beats_zero = (p_len_ff == 7'd0);
   assign sts.out_free        = ~valid_ff | rsp_ready;

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;
   assign rsp_last  = last_ff;

endmodule

`default_nettype wire

// ===== sv/can_capture_block_framer_top.sv =====
// Top level of the CAN capture block framer.
//
// Input stream (req_): one word is a frame descriptor (tuser 0) or a payload
// word of eight data bytes (tuser 1). A descriptor produces the nine header
// words of a pcapng Enhanced Packet Block; payload words add two data words
// each; the block closes with the total length word, flagged by rsp_tlast.
// After the header, zero-length frames get zero data words, then close.
// A descriptor that arrives while a frame is open first pads that frame with
// zero data words and closes it. Payload words with no open frame are dropped.
// Output stream (rsp_): at most one 32-bit word per cycle from an output
// register, held while rsp_tready is low; first stream byte in bits 7:0.
// Order: a taken input word updates the sequencer state register, and each
// output word then passes through the output register. A descriptor that
// closes an open frame sends its zero padding and closing word before the
// new header; the last payload word of a frame adds padding and the close.
// The sequencer emits at most one word per cycle and takes a new input word
// only when idle. req_tready drops while words are produced; a stalled
// rsp_tready holds the output register and the sequencer waits.
// Reset clears the frame state and interface index (csr_wdata, written when
// csr_we is high; the user must write only while the block is idle, unchecked).
`timescale 1ns / 1ps
`default_nettype none

module can_capture_block_framer_top
   import ccbf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [31:0]   csr_wdata,     // interface_index
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tdata: can_id[31:0], is_fd[32], is_error[33], bit_rate_switch[34],
   //        length[41:35], timestamp_us[105:42], payload[169:106], zeros
   input  wire logic [175:0]  req_tdata,
   input  wire logic          req_tuser,     // mode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,     // word
   output logic               rsp_tlast      // last
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   ccbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ccbf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .can_id          (req_tdata[31:0]),
      .is_fd           (req_tdata[32]),
      .is_error        (req_tdata[33]),
      .bit_rate_switch (req_tdata[34]),
      .length          (req_tdata[41:35]),
      .timestamp_us    (req_tdata[105:42]),
      .payload         (req_tdata[169:106]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_word        (rsp_tdata),
      .rsp_last        (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== tb/can_capture_block_framer_top_test.sv =====
// Self-checking testbench for the CAN capture block framer top level.
`timescale 1ns / 1ps

import ccbf_pkg::*;

class epb_scoreboard;
   localparam logic [7:0] BRS_FLAG = 8'h01;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } block_word_type;

   block_word_type block_words_due[$];
   logic [31:0]    if_index;
   bit             frame_open;
   bit             frame_is_fd;
   logic [6:0]     bytes_left;
   logic [3:0]     beats_left;
   logic [4:0]     dwords_left;
   int             failures;
   int             n_effective;

   function new();
      if_index    = '0;
      frame_open  = 1'b0;
      frame_is_fd = 1'b0;
      bytes_left  = '0;
      beats_left  = '0;
      dwords_left = '0;
      failures    = 0;
      n_effective = 0;
   endfunction

   function void set_index(logic [31:0] value);
      if_index = value;
   endfunction

   function int pending();
      return block_words_due.size();
   endfunction

   function void push_word(logic [31:0] word, logic last);
      block_word_type w;
      w.word = word;
      w.last = last;
      block_words_due.push_back(w);
   endfunction

   function logic [31:0] total_len(bit fd);
      return fd ? FD_TOTLEN : CLASSIC_TOTLEN;
   endfunction

   // pad the open block with zero data words, then the closing length
   function void close_block();
      while (dwords_left != 0) begin
         push_word(32'h0, 1'b0);
         dwords_left--;
      end
      push_word(total_len(frame_is_fd), 1'b1);
      frame_open = 1'b0;
      bytes_left = '0;
      beats_left = '0;
   endfunction

   function void predict_block_words(logic mode, logic [175:0] data);
      logic [31:0] id;
      bit          fd;
      bit          err;
      bit          brs;
      logic [6:0]  len;
      logic [63:0] ts;
      logic [63:0] pl;
      logic [63:0] mask;
      logic [7:0]  flags;
      logic [3:0]  take;
      logic [31:0] cap;
      id  = data[31:0];
      fd  = data[32];
      err = data[33];
      brs = data[34];
      len = data[41:35];
      ts  = data[105:42];
      pl  = data[169:106];
      if (mode == MODE_DESC) begin
         n_effective++;
         fd = fd && !err;
         if (frame_open)
            close_block();
         flags = 8'h00;
         if (err) begin
            len = CLASSIC_MAXLEN;
         end else if (fd) begin
            if (len > FD_MAXLEN)
               len = FD_MAXLEN;
            if (brs)
               flags = BRS_FLAG;
         end else if (len > CLASSIC_MAXLEN) begin
            len = CLASSIC_MAXLEN;
         end
         cap = fd ? FD_CAPLEN : CLASSIC_CAPLEN;
         push_word(BLOCK_TYPE_EPB, 1'b0);
         push_word(total_len(fd), 1'b0);
         push_word(if_index, 1'b0);
         push_word(ts[63:32], 1'b0);
         push_word(ts[31:0], 1'b0);
         push_word(cap, 1'b0);
         push_word(cap, 1'b0);
         push_word({id[7:0], id[15:8], id[23:16], id[31:24]}, 1'b0);
         push_word({16'h0, flags, 1'b0, len}, 1'b0);
         frame_open  = 1'b1;
         frame_is_fd = fd;
         bytes_left  = len;
         beats_left  = 4'((len + 7) / 8);
         dwords_left = fd ? FD_DWORDS : CLASSIC_DWORDS;
         if (beats_left == 0)
            close_block();
      end else if (frame_open) begin
         n_effective++;
         take = (bytes_left < 7'd8) ? bytes_left[3:0] : 4'd8;
         mask = (take < 4'd8) ? (64'h1 << (8 * take)) - 64'h1 : {64{1'b1}};
         pl = pl & mask;
         push_word(pl[31:0], 1'b0);
         push_word(pl[63:32], 1'b0);
         bytes_left  = bytes_left - 7'(take);
         dwords_left = (dwords_left >= 5'd2) ? dwords_left - 5'd2 : 5'd0;
         if (beats_left != 0)
            beats_left--;
         if (beats_left == 0)
            close_block();
      end
   endfunction

   function void check_block_word(logic [31:0] word, logic last);
      block_word_type w;
      if (block_words_due.size() == 0) begin
         $error("word: expected none, actual %08h", word);
         failures++;
         return;
      end
      w = block_words_due.pop_front();
      if (word !== w.word) begin
         $error("word: expected %08h, actual %08h", w.word, word);
         failures++;
      end
      if (last !== w.last) begin
         $error("last: expected %0b, actual %0b", w.last, last);
         failures++;
      end
   endfunction
endclass

module can_capture_block_framer_top_test;
   import ccbf_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 32;

   logic          clock;
   logic          reset;
   logic          csr_we;
   logic [31:0]   csr_wdata;
   logic          req_tvalid;
   logic          req_tready;
   logic [175:0]  req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [31:0]   rsp_tdata;
   logic          rsp_tlast;

   epb_scoreboard sb;
   int            send_idle_pct;
   int            recv_stall_pct;
   bit            hold_request;

   can_capture_block_framer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_block_word(rsp_tdata, rsp_tlast);
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [175:0] pack_req(logic [31:0] id, logic fd, logic err, logic brs,
                                             logic [6:0] len, logic [63:0] ts,
                                             logic [63:0] pl);
      return {6'b0, pl, ts, len, brs, err, fd, id};
   endfunction

   function automatic int beats_for(logic fd, logic err, logic [6:0] len);
      int n;
      if (err)
         n = 8;
      else if (fd)
         n = (len > 7'd64) ? 64 : int'(len);
      else
         n = (len > 7'd8) ? 8 : int'(len);
      return (n + 7) / 8;
   endfunction

   task automatic offer_word(input logic mode, input logic [175:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = mode;
      req_tdata  = data;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.predict_block_words(mode, data);
   endtask

   task automatic offer_stray_beat();
      offer_word(MODE_BEAT, pack_req($urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                                     7'($urandom), rand64(), rand64()));
   endtask

   task automatic send_frame(input logic fd, input logic err, input logic brs,
                             input logic [6:0] len, input logic [63:0] ts,
                             input logic [31:0] id, input int n_beats);
      offer_word(MODE_DESC, pack_req(id, fd, err, brs, len, ts, rand64()));
      for (int i = 0; i < n_beats; i++)
         offer_stray_beat();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_index(input logic [31:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      sb.set_index(value);
   endtask

   task automatic run_random(input int n_items);
      int         target;
      int         r;
      int         n_beats;
      logic       fd;
      logic       err;
      logic       brs;
      logic [6:0] len;
      target = sb.n_effective + n_items;
      while (sb.n_effective < target) begin
         r   = $urandom_range(99);
         fd  = 1'($urandom);
         err = ($urandom_range(7) == 0);
         brs = 1'($urandom);
         if ($urandom_range(4) == 0)
            len = 7'($urandom_range(127));
         else
            len = fd ? 7'($urandom_range(64)) : 7'($urandom_range(8));
         n_beats = beats_for(fd, err, len);
         if (r < 78) begin
            send_frame(fd, err, brs, len, rand64(), $urandom, n_beats);
         end else if (r < 90) begin
            // cut short; the next descriptor pads it out
            if (n_beats > 0)
               n_beats = $urandom_range(n_beats - 1);
            send_frame(fd, err, brs, len, rand64(), $urandom, n_beats);
         end else begin
            offer_stray_beat();
         end
      end
   endtask

   initial begin
      int guard;
      sb             = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = MODE_DESC;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      send_idle_pct  = 16;
      recv_stall_pct = 16;
      send_frame(1'b0, 1'b0, 1'b0, 7'd0, 64'h0, 32'h0, 0);
      offer_stray_beat();
      send_frame(1'b0, 1'b0, 1'b1, 7'd8, {64{1'b1}}, 32'hFFFF_FFFF, 1);
      send_frame(1'b0, 1'b0, 1'b0, 7'd3, rand64(), $urandom, 1);
      send_frame(1'b0, 1'b0, 1'b0, 7'd127, rand64(), $urandom, 1);
      send_frame(1'b1, 1'b1, 1'b1, 7'd0, rand64(), $urandom, 1);
      send_frame(1'b1, 1'b0, 1'b1, 7'd64, rand64(), $urandom, 8);
      send_frame(1'b1, 1'b0, 1'b0, 7'd127, rand64(), $urandom, 1);
      send_frame(1'b1, 1'b0, 1'b1, 7'd0, rand64(), $urandom, 0);

      wait_idle();
      write_index(32'hFFFF_FFFF);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      run_random(PHASE_ITEMS);

      wait_idle();
      write_index(32'h0000_0000);
      send_idle_pct = 67;
      run_random(PHASE_ITEMS);

      wait_idle();
      write_index($urandom);
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      run_random(PHASE_ITEMS);

      wait_idle();
      write_index(32'h0000_0001);
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      run_random(PHASE_ITEMS);

      @(negedge clock);
      req_tvalid = 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 200_000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.pending() != 0) begin
         $error("word: expected %0d more, actual none", sb.pending());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
